/* rtl/srect_pkg.sv */
package srect_pkg;

    localparam int COORD_W = 20;
    localparam int UNIT_W  = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = DIFF_W + UNIT_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int MAG_W   = DOT_W + 1;
    localparam int DEN_W   = 38;
    localparam int T_W     = 17;
    localparam int FRAC_W  = 16;
    localparam int REM_W   = DEN_W + FRAC_W + 1;
    localparam int HALF_W  = 19;
    localparam int LIM_W   = HALF_W + 14;
    localparam int DIV_STAGES = T_W;

    localparam logic signed [DOT_W-1:0] DENOM_MAX_REJECT = DOT_W'(4);

    localparam logic [2:0] REG_CENTER = 3'd0;
    localparam logic [2:0] REG_NORMAL = 3'd1;
    localparam logic [2:0] REG_RIGHT  = 3'd2;
    localparam logic [2:0] REG_UP     = 3'd3;
    localparam logic [2:0] REG_HALF_W = 3'd4;
    localparam logic [2:0] REG_HALF_H = 3'd5;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [UNIT_W-1:0]  t_unit;
    typedef logic signed [DIFF_W-1:0]  t_diff;

    typedef struct packed {
        t_coord [2:0]        center;
        t_unit  [2:0]        normal;
        t_unit  [2:0]        right;
        t_unit  [2:0]        up;
        logic   [HALF_W-1:0] half_w;
        logic   [HALF_W-1:0] half_h;
    } t_cfg;

    typedef struct packed {
        t_coord [2:0] start;
        t_diff  [2:0] dir;
        logic         rej;
    } t_side;

endpackage

/* rtl/srect_plane.sv */
module srect_plane
    import srect_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_coord [2:0]     i_start,
    input  t_coord [2:0]     i_end,
    input  t_cfg             i_cfg,
    output logic             o_valid,
    output t_side            o_side,
    output logic [REM_W-1:0] o_rem,
    output logic [DEN_W-1:0] o_dn
);

    logic [4:0] r_v;

    t_coord [2:0] r1_s;
    t_diff  [2:0] r1_d, r1_cs;
    t_coord [2:0] r2_s;
    t_diff  [2:0] r2_d;
    logic signed [2:0][PROD_W-1:0] r2_pd, r2_pc;
    t_coord [2:0] r3_s, r4_s;
    t_diff  [2:0] r3_d, r4_d;
    logic signed [DOT_W-1:0] r3_den, r3_num;
    logic signed [MAG_W-1:0] r4_dn, r4_nm;
    logic r4_small;

    t_diff  [2:0] n1_d, n1_cs;
    logic signed [2:0][PROD_W-1:0] n2_pd, n2_pc;
    logic signed [DOT_W-1:0] n3_den, n3_num;
    logic n5_rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_d[i]  = DIFF_W'($signed(i_end[i])) - DIFF_W'($signed(i_start[i]));
            n1_cs[i] = DIFF_W'($signed(i_cfg.center[i])) - DIFF_W'($signed(i_start[i]));
            n2_pd[i] = PROD_W'($signed(r1_d[i])) * PROD_W'($signed(i_cfg.normal[i]));
            n2_pc[i] = PROD_W'($signed(r1_cs[i])) * PROD_W'($signed(i_cfg.normal[i]));
        end
        n3_den = DOT_W'($signed(r2_pd[0])) + DOT_W'($signed(r2_pd[1]))
               + DOT_W'($signed(r2_pd[2]));
        n3_num = DOT_W'($signed(r2_pc[0])) + DOT_W'($signed(r2_pc[1]))
               + DOT_W'($signed(r2_pc[2]));
        n5_rej = r4_small || r4_nm < 0 || r4_nm > r4_dn;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s  <= i_start;
            r1_d  <= n1_d;
            r1_cs <= n1_cs;
            r2_s  <= r1_s;
            r2_d  <= r1_d;
            r2_pd <= n2_pd;
            r2_pc <= n2_pc;
            r3_s  <= r2_s;
            r3_d  <= r2_d;
            r3_den <= n3_den;
            r3_num <= n3_num;
            r4_s  <= r3_s;
            r4_d  <= r3_d;
            r4_small <= (r3_den >= -DENOM_MAX_REJECT) && (r3_den <= DENOM_MAX_REJECT);
            // flip signs so the divisor is positive
            r4_dn <= (r3_den < 0) ? -MAG_W'(r3_den) : MAG_W'(r3_den);
            r4_nm <= (r3_den < 0) ? -MAG_W'(r3_num) : MAG_W'(r3_num);
            o_side.start <= r4_s;
            o_side.dir   <= r4_d;
            o_side.rej   <= n5_rej;
            // feed a harmless divide for rejected items
            o_dn  <= n5_rej ? DEN_W'(1) : r4_dn[DEN_W-1:0];
            o_rem <= n5_rej ? '0
                   : {1'b0, r4_nm[DEN_W-1:0], {FRAC_W{1'b0}}}
                     + REM_W'(r4_dn[DEN_W-1:1]);
        end
    end

    assign o_valid = r_v[4];

endmodule

/* rtl/srect_div.sv */
module srect_div
    import srect_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_side            i_side,
    input  logic [REM_W-1:0] i_rem,
    input  logic [DEN_W-1:0] i_dn,
    output logic             o_valid,
    output t_side            o_side,
    output logic [T_W-1:0]   o_t
);

    logic             r_v    [DIV_STAGES];
    logic [REM_W-1:0] r_rem  [DIV_STAGES];
    logic [DEN_W-1:0] r_dn   [DIV_STAGES];
    logic [T_W-1:0]   r_q    [DIV_STAGES];
    t_side            r_side [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int BIT = DIV_STAGES - 1 - k;
        logic             p_v;
        logic [REM_W-1:0] p_rem, sh;
        logic [DEN_W-1:0] p_dn;
        logic [T_W-1:0]   p_q;
        t_side            p_side;
        logic             ge;

        if (k == 0) begin : g_first
            assign p_v = i_valid;
            assign p_rem = i_rem;
            assign p_dn = i_dn;
            assign p_q = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v = r_v[k-1];
            assign p_rem = r_rem[k-1];
            assign p_dn = r_dn[k-1];
            assign p_q = r_q[k-1];
            assign p_side = r_side[k-1];
        end

        assign sh = REM_W'(p_dn) << BIT;
        assign ge = p_rem >= sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? p_rem - sh : p_rem;
                r_dn[k]   <= p_dn;
                r_q[k]    <= p_q | (T_W'(ge) << BIT);
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];
    assign o_t     = r_q[DIV_STAGES-1];

endmodule

/* rtl/srect_hit.sv */
module srect_hit
    import srect_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  t_side          i_side,
    input  logic [T_W-1:0] i_t,
    input  t_cfg           i_cfg,
    output logic           o_valid,
    output logic           o_hit,
    output t_coord [2:0]   o_point,
    output logic [T_W-1:0] o_t
);

    localparam int P_W = DIFF_W + T_W + 1;
    localparam int M_W = P_W - FRAC_W;
    localparam int H_W = COORD_W + 2;

    logic [6:0] r_v;
    logic [5:0] r_rej;
    logic [T_W-1:0] r_t [6];
    t_coord [2:0] r1_s, r2_s;
    logic signed [2:0][P_W-1:0] r1_p;
    logic [2:0] r2_neg;
    logic [2:0][M_W-1:0] r2_mag;
    t_coord [2:0] r3_h, r4_h, r5_h, r6_h;
    t_diff  [2:0] r4_loc;
    logic signed [2:0][PROD_W-1:0] r5_pr, r5_pu;
    logic signed [DOT_W-1:0] r6_pw, r6_ph;

    logic signed [2:0][P_W-1:0] n1_p;
    logic [2:0][P_W-1:0] n2_abs;
    logic signed [2:0][H_W-1:0] n3_h;
    t_diff [2:0] n4_loc;
    logic signed [2:0][PROD_W-1:0] n5_pr, n5_pu;
    logic signed [DOT_W-1:0] n6_pw, n6_ph, lim_w, lim_h;
    logic n7_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_p[i] = P_W'($signed(i_side.dir[i])) * P_W'($signed({1'b0, i_t}));
            n2_abs[i] = ($signed(r1_p[i]) < 0) ? -r1_p[i] : r1_p[i];
            n3_h[i] = r2_neg[i] ? H_W'($signed(r2_s[i])) - H_W'(r2_mag[i])
                                : H_W'($signed(r2_s[i])) + H_W'(r2_mag[i]);
            n4_loc[i] = DIFF_W'($signed(r3_h[i])) - DIFF_W'($signed(i_cfg.center[i]));
            n5_pr[i] = PROD_W'($signed(r4_loc[i])) * PROD_W'($signed(i_cfg.right[i]));
            n5_pu[i] = PROD_W'($signed(r4_loc[i])) * PROD_W'($signed(i_cfg.up[i]));
        end
        n6_pw = DOT_W'($signed(r5_pr[0])) + DOT_W'($signed(r5_pr[1]))
              + DOT_W'($signed(r5_pr[2]));
        n6_ph = DOT_W'($signed(r5_pu[0])) + DOT_W'($signed(r5_pu[1]))
              + DOT_W'($signed(r5_pu[2]));
        lim_w = $signed(DOT_W'({i_cfg.half_w, 14'b0}));
        lim_h = $signed(DOT_W'({i_cfg.half_h, 14'b0}));
        // an extent exactly on the edge counts as a hit
        n7_hit = !r_rej[5] && r6_pw <= lim_w && r6_pw >= -lim_w
                 && r6_ph <= lim_h && r6_ph >= -lim_h;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rej <= {r_rej[4:0], i_side.rej};
            r_t[0] <= i_t;
            for (int k = 1; k < 6; k++) begin
                r_t[k] <= r_t[k-1];
            end
            r1_s <= i_side.start;
            r1_p <= n1_p;
            r2_s <= r1_s;
            for (int i = 0; i < 3; i++) begin
                r2_neg[i] <= $signed(r1_p[i]) < 0;
                r2_mag[i] <= M_W'((n2_abs[i] + P_W'(1 << (FRAC_W - 1))) >> FRAC_W);
                r3_h[i] <= n3_h[i][COORD_W-1:0];
            end
            r4_h <= r3_h;
            r4_loc <= n4_loc;
            r5_h <= r4_h;
            r5_pr <= n5_pr;
            r5_pu <= n5_pu;
            r6_h <= r5_h;
            r6_pw <= n6_pw;
            r6_ph <= n6_ph;
            // zero every field on a miss
            o_hit <= n7_hit;
            o_point <= n7_hit ? r6_h : '0;
            o_t <= n7_hit ? r_t[5] : '0;
        end
    end

    assign o_valid = r_v[6];

endmodule

/* rtl/segment_rectangle_intersect.sv */
// Channel   Direction  Handshake            Content
// s_axis    in         i_s_tvalid/o_s_tready start_xyz, end_xyz
// m_axis    out        o_m_tvalid/i_m_tready hit point, t; tuser = hit
// apb       in         i_psel/i_penable      rectangle registers at 8*index
//
// One transaction per cycle enters while the output is not stalled; each result
// passes 5 plane stages, 17 divider stages of one quotient bit each and 7 hit
// stages, the last of which is the output register. Reset clears all valid
// bits and the rectangle registers. A stall on the output freezes the whole
// pipeline; nothing is lost or repeated, and the input is taken whenever the
// output register can move.
module segment_rectangle_intersect
    import srect_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (20 bits each)
    input  logic [119:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // hit_x, hit_y, hit_z (20 bits each), hit_fraction (17), zero pad (3)
    output logic [79:0]  o_m_tdata,
    // hit
    output logic         o_m_tuser,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [5:0]   i_paddr,
    input  logic [63:0]  i_pwdata,
    output logic [63:0]  o_prdata,
    output logic         o_pready
);

    logic [59:0] r_center;
    logic [47:0] r_normal, r_right, r_up;
    logic [HALF_W-1:0] r_half_w, r_half_h;
    t_cfg cfg;

    logic en, wr;
    t_coord [2:0] start, stop;
    logic pl_valid, dv_valid, ht_valid, ht_hit;
    t_side pl_side, dv_side;
    logic [REM_W-1:0] pl_rem;
    logic [DEN_W-1:0] pl_dn;
    logic [T_W-1:0] dv_t, ht_t;
    t_coord [2:0] ht_point;

    assign o_pready = 1'b1;
    assign wr = i_psel && i_penable && i_pwrite;

    // take register writes; user keeps block idle as they arrive, unchecked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_normal <= '0;
            r_right  <= '0;
            r_up     <= '0;
            r_half_w <= '0;
            r_half_h <= '0;
        end else if (wr) begin
            case (i_paddr[5:3])
                REG_CENTER: r_center <= i_pwdata[59:0];
                REG_NORMAL: r_normal <= i_pwdata[47:0];
                REG_RIGHT:  r_right  <= i_pwdata[47:0];
                REG_UP:     r_up     <= i_pwdata[47:0];
                REG_HALF_W: r_half_w <= i_pwdata[HALF_W-1:0];
                REG_HALF_H: r_half_h <= i_pwdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[5:3])
            REG_CENTER: o_prdata = 64'(r_center);
            REG_NORMAL: o_prdata = 64'(r_normal);
            REG_RIGHT:  o_prdata = 64'(r_right);
            REG_UP:     o_prdata = 64'(r_up);
            REG_HALF_W: o_prdata = 64'(r_half_w);
            REG_HALF_H: o_prdata = 64'(r_half_h);
            default:    o_prdata = '0;
        endcase
    end

    assign cfg.center = r_center;
    assign cfg.normal = r_normal;
    assign cfg.right  = r_right;
    assign cfg.up     = r_up;
    assign cfg.half_w = r_half_w;
    assign cfg.half_h = r_half_h;

    // advance the pipeline unless a result is held at the output
    assign en = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    assign start = i_s_tdata[59:0];
    assign stop  = i_s_tdata[119:60];

    srect_plane u_plane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_start (start),
        .i_end   (stop),
        .i_cfg   (cfg),
        .o_valid (pl_valid),
        .o_side  (pl_side),
        .o_rem   (pl_rem),
        .o_dn    (pl_dn)
    );

    srect_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pl_valid),
        .i_side  (pl_side),
        .i_rem   (pl_rem),
        .i_dn    (pl_dn),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_t     (dv_t)
    );

    srect_hit u_hit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_side  (dv_side),
        .i_t     (dv_t),
        .i_cfg   (cfg),
        .o_valid (ht_valid),
        .o_hit   (ht_hit),
        .o_point (ht_point),
        .o_t     (ht_t)
    );

    assign o_m_tvalid = ht_valid;
    assign o_m_tuser  = ht_hit;
    assign o_m_tdata  = {3'b000, ht_t, ht_point};

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("miss result carries nonzero fields");
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[76:60] <= 17'd65536))
        else $error("hit fraction above one");
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_m_tvalid)
        else $error("result valid right after reset");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");
`endif

endmodule
